>>> rtl/hole_allocator_first_best_fit_unit_assert.svh
// Assertion macros for the hole allocator unit.
// Included by the top level; no other dependencies.
`ifndef HOLE_ALLOCATOR_FIRST_BEST_FIT_UNIT_ASSERT_SVH
`define HOLE_ALLOCATOR_FIRST_BEST_FIT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Concurrent assertion on a given clock and active-low reset.
`define HAFB_ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hole allocator assertion failed");
// Same, on the default clock and reset names.
`define HAFB_ASSERT(lbl, prop) `HAFB_ASSERT_AT(lbl, clk_i, rst_ni, prop)
`else
`define HAFB_ASSERT_AT(lbl, clk, rst_n, prop)
`define HAFB_ASSERT(lbl, prop)
`endif

`endif

>>> rtl/hafb_pkg.sv
// Shared types and constants for the hole allocator unit.
// No dependencies.
package hafb_pkg;

  localparam int NUM_HOLES_DEF = 16;
  localparam int SIZE_BITS_DEF = 16;
  localparam int HOLE_IDX_W    = 4;
  localparam int FIELD_W       = 16;
  localparam int CNT_W         = 5;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  localparam logic MODE_FIRST = 1'b0;
  localparam logic MODE_BEST  = 1'b1;

  localparam logic REG_FIT_MODE   = 1'b0;
  localparam logic REG_HOLE_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] HOLE_COUNT_RST = CNT_W'(16);

  typedef struct packed {
    logic                  kind;
    logic [HOLE_IDX_W-1:0] hole_index;
    logic [FIELD_W-1:0]    size;
  } in_item_t;

  typedef struct packed {
    logic                  granted;
    logic [HOLE_IDX_W-1:0] chosen_hole;
    logic [FIELD_W-1:0]    remaining;
  } out_item_t;

  typedef struct packed {
    logic capture;  // latch the accepted item, clear the search
    logic step;     // advance the scan by one entry
    logic finish;   // write back and load the result register
  } hafb_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } hafb_stat_t;

endpackage

>>> rtl/hafb_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module hafb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/hafb_ctrl.sv
// Sequencer for the hole allocator: accept, scan, write back.
// Depends on hafb_pkg.
module hafb_ctrl
  import hafb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_kind_i,
  output logic       in_ready_o,
  input  hafb_stat_t stat_i,
  output hafb_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (in_kind_i == KIND_REQ) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/hafb_dpath.sv
// Datapath for the hole allocator: free-size RAM, scan pointer, best pick, result.
// Depends on hafb_pkg and hafb_ram.
module hafb_dpath
  import hafb_pkg::*;
#(
  parameter int NUM_HOLES = NUM_HOLES_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hafb_cmd_t        cmd_i,
  output hafb_stat_t       stat_o,
  input  in_item_t         in_item_i,
  input  logic             fit_mode_i,
  input  logic [CNT_W-1:0] hole_count_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output out_item_t        out_item_o
);

  localparam int AW = $clog2(NUM_HOLES);
  localparam int PW = $clog2(NUM_HOLES + 1);
  localparam int CW = (PW > CNT_W) ? PW : CNT_W;
  localparam int LW = (PW > HOLE_IDX_W) ? PW : HOLE_IDX_W;
  localparam int SW = (SIZE_BITS > FIELD_W) ? SIZE_BITS : FIELD_W;

  logic                  kind_q;
  logic [HOLE_IDX_W-1:0] idx_q;
  logic [SIZE_BITS-1:0]  size_q;
  logic [PW-1:0]         ptr_q;
  logic                  pend_q, pend_vld_q;
  logic [AW-1:0]         pend_idx_q;
  logic                  found_q;
  logic [AW-1:0]         best_idx_q;
  logic [SIZE_BITS-1:0]  best_val_q;
  logic [NUM_HOLES-1:0]  valid_q;
  logic                  out_valid_q;
  out_item_t             out_q;

  logic [SW-1:0]         size_wide;
  logic [CW-1:0]         active;
  logic                  more, halt, issue, take, fits;
  logic [SIZE_BITS-1:0]  rd_data, rd_val, new_val, wr_data, rem_val;
  logic [LW-1:0]         idx_wide;
  logic                  ld_ok, is_load, wr_en;
  logic [AW-1:0]         wr_addr;

  assign size_wide = SW'(in_item_i.size);
  assign active    = (CW'(hole_count_i) > CW'(NUM_HOLES)) ? CW'(NUM_HOLES)
                                                         : CW'(hole_count_i);
  assign more      = CW'(ptr_q) < active;
  // First fit stops reading once a hole is found.
  assign halt      = found_q && (fit_mode_i == MODE_FIRST);
  assign issue     = cmd_i.step && more && !halt;

  assign rd_val  = pend_vld_q ? rd_data : '0;
  assign fits    = rd_val >= size_q;
  assign take    = cmd_i.step && pend_q && fits &&
                   (!found_q || ((fit_mode_i == MODE_BEST) && (rd_val < best_val_q)));

  assign stat_o.scan_done = !pend_q && !(more && !halt);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign is_load  = (kind_q == KIND_LOAD);
  assign idx_wide = LW'(idx_q);
  assign ld_ok    = idx_wide < LW'(NUM_HOLES);
  assign new_val  = best_val_q - size_q;
  assign wr_en    = cmd_i.finish && (is_load ? ld_ok : found_q);
  assign wr_addr  = is_load ? idx_wide[AW-1:0] : best_idx_q;
  assign wr_data  = is_load ? size_q : new_val;
  assign rem_val  = is_load ? (ld_ok ? size_q : '0) : (found_q ? new_val : '0);

  hafb_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_HOLES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (issue),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= in_item_i.kind;
      idx_q  <= in_item_i.hole_index;
      size_q <= size_wide[SIZE_BITS-1:0];
    end
    if (issue) begin
      pend_idx_q <= ptr_q[AW-1:0];
      pend_vld_q <= valid_q[ptr_q[AW-1:0]];
    end
    if (take) begin
      best_idx_q <= pend_idx_q;
      best_val_q <= rd_val;
    end
    if (cmd_i.finish) begin
      out_q.granted     <= !is_load && found_q;
      out_q.chosen_hole <= is_load ? idx_q : (found_q ? HOLE_IDX_W'(best_idx_q) : '0);
      out_q.remaining   <= FIELD_W'(SW'(rem_val));
    end
  end

  // Scan control, entry valid bits and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        ptr_q   <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
      end else if (cmd_i.step) begin
        pend_q <= issue;
        if (issue) begin
          ptr_q <= ptr_q + PW'(1);
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> rtl/hole_allocator_first_best_fit_unit.sv
// Top level of the hole allocator: APB registers, sequencer and datapath.
// Depends on hafb_pkg, hafb_ctrl, hafb_dpath and the assertion header.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_item_i) takes one item per
//   transfer: kind load writes a hole's total size, kind request asks for
//   space. Output channel (out_valid_o/out_ready_i, out_item_o) returns one
//   result per item, in order.
//   A load goes from its transfer through the write-back step into the
//   output register, and the unit takes the next item once it is back in
//   idle. A request scans the free-size RAM one entry per cycle through
//   its single read port, over the entries below A, the active hole count
//   min(hole_count, NUM_HOLES); first fit ends the scan one entry after
//   the first fitting hole. One item is in work at a time.
//   The result sits in an output register, so the next item is taken while
//   a result waits; when the receiver stalls, a finished item holds in the
//   write-back step until the output register frees.
//   Reset: all holes read as free size zero (per-entry valid bits, no
//   clearing pass), fit_mode = first fit, hole_count = 16.
//   Registers: 0x0 fit_mode, 0x4 hole_count; write only while idle.
`include "hole_allocator_first_best_fit_unit_assert.svh"

module hole_allocator_first_best_fit_unit
  import hafb_pkg::*;
#(
  parameter int NUM_HOLES = NUM_HOLES_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic             fit_mode_q;
  logic [CNT_W-1:0] hole_count_q;
  logic             cfg_wr;
  logic             reg_sel;
  hafb_cmd_t        cmd;
  hafb_stat_t       stat;

  // Register file: one word per register, decoded on address bit 2.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q   <= MODE_FIRST;
      hole_count_q <= HOLE_COUNT_RST;
    end else if (cfg_wr) begin
      if (reg_sel == REG_FIT_MODE) begin
        fit_mode_q <= pwdata[0];
      end else begin
        hole_count_q <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      REG_FIT_MODE:   prdata = PDATA_W'(fit_mode_q);
      REG_HOLE_COUNT: prdata = PDATA_W'(hole_count_q);
      default:        prdata = '0;
    endcase
  end

  // Sequence each item: capture, scan (requests only), write back.
  hafb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_item_i.kind),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold free sizes, pick the hole, drive the result register.
  hafb_dpath #(
    .NUM_HOLES (NUM_HOLES),
    .SIZE_BITS (SIZE_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_item_i    (in_item_i),
    .fit_mode_i   (fit_mode_q),
    .hole_count_i (hole_count_q),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_item_o   (out_item_o)
  );

  // Busy right after a transfer in: one item at a time.
  `HAFB_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o)
  // Never overwrite a result the receiver has not taken.
  `HAFB_ASSERT(a_no_result_overwrite, cmd.finish |-> (!out_valid_o || out_ready_i))
  // Write-back always presents a result on the next cycle.
  `HAFB_ASSERT(a_result_after_finish, cmd.finish |=> out_valid_o)
  // Commands are exclusive.
  `HAFB_ASSERT(a_cmd_exclusive, $onehot0({cmd.capture, cmd.step, cmd.finish}))

endmodule

>>> test/tb.sv
// Self-checking testbench for hole_allocator_first_best_fit_unit.
// Depends on hafb_pkg and the unit's RTL; drives both streams and the APB port.

module tb;
  import hafb_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int SETTLE_CYC  = 48;       // longest scan plus write-back, with margin
  localparam int CYCLE_LIMIT = 1000000;
  localparam int IDLE_PCT    = 23;

  // DUT connections; every input starts at a known value
  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  in_item_t            in_item    = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  out_item_t           out_item;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [PADDR_W-1:0]  paddr      = '0;
  logic [PDATA_W-1:0]  pwdata     = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Shadow state of the allocator
  logic [FIELD_W-1:0]  shadow_free [NUM_HOLES_DEF];
  logic                shadow_mode;
  logic [CNT_W-1:0]    shadow_count;

  out_item_t           pending_results [$];
  int unsigned         err_count    = 0;
  bit                  calm         = 1'b0;  // no idling on either side
  int unsigned         hold_request = 0;     // receiver hold-off, in cycles

  hole_allocator_first_best_fit_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop: the slowest legal run stays far below this
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Work out the result of one accepted item and update the shadow holes.
  function automatic out_item_t predict_alloc(input in_item_t it);
    out_item_t res;
    int        active;
    bit        found;
    int        pick;
    res   = '0;
    found = 1'b0;
    pick  = 0;
    if (it.kind == KIND_LOAD) begin
      shadow_free[it.hole_index] = it.size;
      res.chosen_hole = it.hole_index;
      res.remaining   = it.size;
    end else begin
      // saturate the active count to the number of holes
      active = (shadow_count > NUM_HOLES_DEF) ? NUM_HOLES_DEF : int'(shadow_count);
      for (int h = 0; h < active; h++) begin
        if (shadow_free[h] >= it.size) begin
          if (!found) begin
            found = 1'b1;
            pick  = h;
            if (shadow_mode == MODE_FIRST) break;
          end else if (shadow_free[h] < shadow_free[pick]) begin
            pick = h;   // strictly smaller only, so ties keep the lowest index
          end
        end
      end
      if (found) begin
        shadow_free[pick] = shadow_free[pick] - it.size;
        res.granted     = 1'b1;
        res.chosen_hole = HOLE_IDX_W'(pick);
        res.remaining   = shadow_free[pick];
      end
    end
    return res;
  endfunction

  // Receiver: random stalls, plus a counted hold-off on request.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare every result transfer against the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result granted=%0b hole=%0d remaining=%h",
                 $time, out_item.granted, out_item.chosen_hole, out_item.remaining);
      end else begin
        want = pending_results.pop_front();
        if (out_item.granted !== want.granted) begin
          err_count++;
          $display("%0t: granted expected %0b actual %0b",
                   $time, want.granted, out_item.granted);
        end
        if (out_item.chosen_hole !== want.chosen_hole) begin
          err_count++;
          $display("%0t: chosen_hole expected %0d actual %0d",
                   $time, want.chosen_hole, out_item.chosen_hole);
        end
        if (out_item.remaining !== want.remaining) begin
          err_count++;
          $display("%0t: remaining expected %h actual %h",
                   $time, want.remaining, out_item.remaining);
        end
      end
    end
  end

  // Offer one item; return once its transfer has happened.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_alloc(it));
  endtask

  task automatic send_fields(input logic kind, input int unsigned idx,
                             input int unsigned size);
    in_item_t it;
    it.kind       = kind;
    it.hole_index = HOLE_IDX_W'(idx);
    it.size       = FIELD_W'(size);
    send_item(it);
  endtask

  // Drop valid, wait for every outstanding result, then let the unit settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // APB write followed by a read back of the same register.
  task automatic write_reg(input logic idx, input int unsigned value);
    logic [PDATA_W-1:0] mask;
    logic [PDATA_W-1:0] got;
    mask = (idx == REG_FIT_MODE) ? PDATA_W'(1) : PDATA_W'((1 << CNT_W) - 1);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * idx);
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_FIT_MODE) shadow_mode = value[0];
    else                     shadow_count = value[CNT_W-1:0];
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== (PDATA_W'(value) & mask)) begin
      err_count++;
      $display("%0t: register %0d read expected %h actual %h",
               $time, idx, PDATA_W'(value) & mask, got);
    end
  endtask

  // Size with a random magnitude so that small requests still fit often.
  function automatic int unsigned rand_size(input int unsigned cap);
    int unsigned s;
    case ($urandom_range(19))
      0:       s = 0;
      1:       s = (1 << FIELD_W) - 1;
      2, 3:    s = $urandom_range((1 << FIELD_W) - 1);
      default: s = $urandom_range((1 << $urandom_range(FIELD_W - 1)) - 1);
    endcase
    return (s > cap) ? cap : s;
  endfunction

  // After reset every hole reads empty, so only a zero request fits.
  task automatic test_reset_state();
    send_fields(KIND_REQ, 9, 0);        // zero-size request lands on hole 0
    send_fields(KIND_REQ, 0, 1);        // nothing fits
    drain();
  endtask

  task automatic test_first_fit();
    send_fields(KIND_LOAD, 15, 16'hFFFF);
    send_fields(KIND_LOAD, 3, 16'h0100);
    send_fields(KIND_LOAD, 7, 16'h0200);
    send_fields(KIND_REQ, 15, 16'h0100);  // exact fit on the lowest fitting hole
    send_fields(KIND_REQ, 0, 16'h0101);
    send_fields(KIND_REQ, 5, 16'hFFFF);   // largest request drains hole 15
    send_fields(KIND_REQ, 5, 16'hFFFF);   // nothing fits any more
    drain();
  endtask

  task automatic test_best_fit();
    write_reg(REG_FIT_MODE, MODE_BEST);
    send_fields(KIND_LOAD, 1, 16'h0050);
    send_fields(KIND_LOAD, 2, 16'h0030);
    send_fields(KIND_LOAD, 9, 16'h0030);  // tie with hole 2
    send_fields(KIND_REQ, 0, 16'h0020);   // tie goes to the lower index
    send_fields(KIND_REQ, 0, 16'h0030);
    send_fields(KIND_REQ, 0, 16'h0000);   // zero request picks the smallest hole
    drain();
  endtask

  task automatic test_hole_count();
    write_reg(REG_HOLE_COUNT, 0);
    send_fields(KIND_REQ, 0, 0);          // no active hole at all
    drain();
    write_reg(REG_HOLE_COUNT, (1 << CNT_W) - 1);  // saturates to all holes
    send_fields(KIND_LOAD, 15, 16'h8000);
    send_fields(KIND_REQ, 0, 16'h7000);
    drain();
    write_reg(REG_HOLE_COUNT, 1);
    write_reg(REG_FIT_MODE, MODE_FIRST);
    send_fields(KIND_LOAD, 12, 16'hAAAA); // written while inactive
    send_fields(KIND_REQ, 12, 1);
    drain();
    write_reg(REG_HOLE_COUNT, 13);
    send_fields(KIND_REQ, 3, 16'h5555);   // hole 12 is back in the search
    send_fields(KIND_LOAD, 0, 16'hFFFF);
    drain();
  endtask

  // One burst of traffic: mostly refill-then-allocate runs, some noise.
  task automatic run_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned active;
    int unsigned last_size;
    int unsigned n;
    sent      = 0;
    last_size = (1 << FIELD_W) - 1;
    active    = (shadow_count == 0) ? 1 :
                (shadow_count > NUM_HOLES_DEF) ? NUM_HOLES_DEF : shadow_count;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          last_size = rand_size((1 << FIELD_W) - 1);
          send_fields(KIND_LOAD, $urandom_range(active - 1), last_size);
          sent++;
        end
        n = $urandom_range(2, 8);
        repeat (n) begin
          send_fields(KIND_REQ, $urandom_range(NUM_HOLES_DEF - 1),
                      $urandom_range(1) ? rand_size(last_size) : rand_size(last_size / 4));
          sent++;
        end
      end else begin
        send_fields(1'($urandom_range(1)), $urandom_range(NUM_HOLES_DEF - 1),
                    $urandom_range((1 << FIELD_W) - 1));
        sent++;
      end
    end
  endtask

  // Hold the receiver off so the unit fills and stalls its input.
  task automatic test_backpressure();
    write_reg(REG_HOLE_COUNT, NUM_HOLES_DEF);
    calm         = 1'b1;
    hold_request = 300;
    run_traffic(40);
    calm = 1'b0;
    drain();
  endtask

  // Random phases over a spread of settings, extremes included.
  task automatic test_random();
    int unsigned counts [10] = '{16, 1, 31, 2, 0, 16, 8, 17, 15, 16};
    int unsigned cnt;
    for (int p = 0; p < 10; p++) begin
      cnt = (p == 6) ? $urandom_range((1 << CNT_W) - 1) : counts[p];
      write_reg(REG_FIT_MODE, p % 2);
      write_reg(REG_HOLE_COUNT, cnt);
      calm = (p == 3);   // one phase with no idling on either side
      run_traffic((cnt == 0) ? 60 : 180);
      calm = 1'b0;
      drain();
    end
  endtask

  initial begin
    for (int h = 0; h < NUM_HOLES_DEF; h++) shadow_free[h] = '0;
    shadow_mode  = MODE_FIRST;
    shadow_count = HOLE_COUNT_RST;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_reset_state();
    test_first_fit();
    test_best_fit();
    test_hole_count();
    test_backpressure();
    test_random();

    drain();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
